// ----- design/msp_pkg.sv -----
// Shared types and constants for the multichannel servo pulse generator.
package msp_pkg;

	localparam int MAX_CHANNELS = 8;
	localparam int CHAN_BITS    = 3;
	localparam int PACK_BITS    = 12;
	localparam int REG_BITS     = 48;
	localparam int PERIOD_BITS  = 15;
	localparam int PCT_BITS     = 7;
	localparam int READ_BITS    = 12;
	localparam int CFG_IDX_BITS = 3;

	localparam int DEF_CHANNELS   = 8;
	localparam int DEF_WIDTH_BITS = 12;

	typedef logic [1:0] func_t;
	localparam func_t FUNC_TICK = 2'd0;
	localparam func_t FUNC_SET  = 2'd1;
	localparam func_t FUNC_READ = 2'd2;

	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_PERIOD = 3'd0;
	localparam cfg_idx_t REG_MIN_LO = 3'd1;
	localparam cfg_idx_t REG_MIN_HI = 3'd2;
	localparam cfg_idx_t REG_MAX_LO = 3'd3;
	localparam cfg_idx_t REG_MAX_HI = 3'd4;

	localparam logic [PERIOD_BITS-1:0] RESET_PERIOD = 15'd20000;
	localparam logic [REG_BITS-1:0]    RESET_MINS   = 48'd65299445146550;
	localparam logic [REG_BITS-1:0]    RESET_MAXS   = 48'd140909329000450;
	localparam int                     RESET_WIDTH  = 1500;
	localparam logic [PCT_BITS-1:0]    FULL_SCALE   = 7'd100;

	// floor(x / 100) == (x * DIV_RECIP) >> DIV_SHIFT for x below 2^20
	localparam int                     PROD_BITS = PACK_BITS + PCT_BITS;
	localparam int                     DIV_SHIFT = 26;
	localparam int                     RECIP_BITS = 20;
	localparam logic [RECIP_BITS-1:0]  DIV_RECIP = 20'd671089;
	localparam int                     DIVP_BITS = PROD_BITS + RECIP_BITS;

	typedef struct packed {
		logic                 valid;
		logic [CHAN_BITS-1:0] channel;
		logic [PACK_BITS-1:0] width;
	} map_wr_t;

	typedef struct packed {
		logic [MAX_CHANNELS-1:0] pin_levels;
		logic [READ_BITS-1:0]    width_readback;
		logic                    period_start;
	} result_t;

endpackage

// ----- design/msp_req_if.sv -----
// Request channel: tick, set and read items.
interface msp_req_if;
	logic                            valid;
	logic                            ready;
	msp_pkg::func_t                  func;
	logic [msp_pkg::CHAN_BITS-1:0]   channel;
	logic [msp_pkg::PCT_BITS-1:0]    percentage;

	modport source (output valid, output func, output channel, output percentage, input ready);
	modport sink (input valid, input func, input channel, input percentage, output ready);
endinterface

// ----- design/msp_rsp_if.sv -----
// Result channel: pin levels, width readback and frame start flag.
interface msp_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [msp_pkg::MAX_CHANNELS-1:0]   pin_levels;
	logic [msp_pkg::READ_BITS-1:0]      width_readback;
	logic                               period_start;

	modport source (output valid, output pin_levels, output width_readback,
		output period_start, input ready);
	modport sink (input valid, input pin_levels, input width_readback,
		input period_start, output ready);
endinterface

// ----- design/msp_cfg_if.sv -----
// Configuration write channel.
interface msp_cfg_if;
	logic                           valid;
	logic                           ready;
	msp_pkg::cfg_idx_t              index;
	logic [msp_pkg::REG_BITS-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/msp_map.sv -----
// Two-stage percentage to pulse width mapper: multiply, then divide by 100.
module msp_map (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [msp_pkg::CHAN_BITS-1:0]    channel,
	input  logic [msp_pkg::PCT_BITS-1:0]     percentage,
	input  logic [msp_pkg::REG_BITS-1:0]     min_lo,
	input  logic [msp_pkg::REG_BITS-1:0]     min_hi,
	input  logic [msp_pkg::REG_BITS-1:0]     max_lo,
	input  logic [msp_pkg::REG_BITS-1:0]     max_hi,
	output msp_pkg::map_wr_t                 wr
);
	import msp_pkg::*;

	logic [REG_BITS-1:0]  min_word;
	logic [REG_BITS-1:0]  max_word;
	logic [PACK_BITS-1:0] lo;
	logic [PACK_BITS-1:0] hi;
	logic [PACK_BITS-1:0] diff;
	logic [PCT_BITS-1:0]  pct;
	logic                 down;
	logic [PROD_BITS-1:0] prod;

	logic                 valid_s1;
	logic [CHAN_BITS-1:0] channel_s1;
	logic [PACK_BITS-1:0] lo_s1;
	logic                 down_s1;
	logic [PROD_BITS-1:0] prod_s1;

	logic [DIVP_BITS-1:0] quot_full;
	logic [PACK_BITS-1:0] quot;

	always_comb begin
		min_word = channel[CHAN_BITS-1] ? min_hi : min_lo;
		max_word = channel[CHAN_BITS-1] ? max_hi : max_lo;
		lo       = min_word[channel[1:0]*PACK_BITS +: PACK_BITS];
		hi       = max_word[channel[1:0]*PACK_BITS +: PACK_BITS];
		down     = hi < lo;
		diff     = down ? (lo - hi) : (hi - lo);
		pct      = (percentage > FULL_SCALE) ? FULL_SCALE : percentage;
		prod     = PROD_BITS'(diff) * PROD_BITS'(pct);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			channel_s1 <= channel;
			lo_s1      <= lo;
			down_s1    <= down;
			prod_s1    <= prod;
		end
	end

	always_comb begin
		quot_full  = DIVP_BITS'(prod_s1) * DIVP_BITS'(DIV_RECIP);
		quot       = quot_full[DIV_SHIFT +: PACK_BITS];
		wr.valid   = valid_s1;
		wr.channel = channel_s1;
		wr.width   = down_s1 ? (lo_s1 - quot) : (lo_s1 + quot);
	end

endmodule

// ----- design/multichannel_servo_pwm.sv -----
// Top level: eight-channel RC servo pulse generator on a 1 us tick time base.
//
//  channel | dir | payload                                   | handshake
//  req     | in  | func, channel, percentage                 | valid/ready
//  rsp     | out | pin_levels, width_readback, period_start   | valid/ready
//  cfg     | in  | index, data                               | valid/ready, always ready
//
// One item per cycle while the skid entry is free; each result is registered
// and offered the cycle after its item unless rsp stalls. A set item's width
// passes the mapper's multiply stage register, then its reciprocal divide, into
// the pending slot; a frame-start tick while the mapper output is valid takes
// that width directly. Reset clears all control state; no clearing pass.
// A two-entry result buffer keeps req flowing while rsp stalls for one item.
module multichannel_servo_pwm #(
	parameter int CHANNELS   = msp_pkg::DEF_CHANNELS,
	parameter int WIDTH_BITS = msp_pkg::DEF_WIDTH_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	msp_req_if.sink     req,
	msp_rsp_if.source   rsp,
	msp_cfg_if.sink     cfg
);
	import msp_pkg::*;

	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CMP_W    = (WIDTH_BITS > PERIOD_BITS) ? WIDTH_BITS : PERIOD_BITS;

	logic [PERIOD_BITS-1:0] period_q;
	logic [REG_BITS-1:0]    min_lo_q;
	logic [REG_BITS-1:0]    min_hi_q;
	logic [REG_BITS-1:0]    max_lo_q;
	logic [REG_BITS-1:0]    max_hi_q;

	logic [PERIOD_BITS-1:0] count_q;
	logic [WIDTH_BITS-1:0]  active_q  [CHANNELS];
	logic [WIDTH_BITS-1:0]  pending_q [CHANNELS];
	logic [CHANNELS-1:0]    flag_q;
	logic [CHANNELS-1:0]    pin_q;

	result_t main_q;
	result_t skid_q;
	logic    main_v_q;
	logic    skid_v_q;

	map_wr_t wr;

	logic                   accept;
	logic                   pop;
	logic                   ch_ok;
	logic [CH_IDX_W-1:0]    ch_idx;
	logic                   is_tick;
	logic                   is_set;
	logic                   is_read;
	logic                   frame_start;
	logic [WIDTH_BITS-1:0]  pend_eff [CHANNELS];
	logic [WIDTH_BITS-1:0]  act_eff [CHANNELS];
	logic [CHANNELS-1:0]    pins_next;
	logic [PERIOD_BITS-1:0] count_inc;
	logic [PERIOD_BITS-1:0] count_next;
	result_t                res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= RESET_PERIOD;
			min_lo_q <= RESET_MINS;
			min_hi_q <= RESET_MINS;
			max_lo_q <= RESET_MAXS;
			max_hi_q <= RESET_MAXS;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PERIOD: period_q <= cfg.data[PERIOD_BITS-1:0];
				REG_MIN_LO: min_lo_q <= cfg.data;
				REG_MIN_HI: min_hi_q <= cfg.data;
				REG_MAX_LO: max_lo_q <= cfg.data;
				REG_MAX_HI: max_hi_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		is_tick     = req.func == FUNC_TICK;
		is_set      = req.func == FUNC_SET;
		is_read     = req.func == FUNC_READ;
		ch_ok       = {1'b0, req.channel} < (CHAN_BITS + 1)'(CHANNELS);
		ch_idx      = req.channel[CH_IDX_W-1:0];
		frame_start = count_q == '0;
		req.ready   = !skid_v_q;
		accept      = req.valid && req.ready;
		pop         = main_v_q && rsp.ready;
	end

	msp_map u_map (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept && is_set && ch_ok),
		.channel    (req.channel),
		.percentage (req.percentage),
		.min_lo     (min_lo_q),
		.min_hi     (min_hi_q),
		.max_lo     (max_lo_q),
		.max_hi     (max_hi_q),
		.wr         (wr)
	);

	always_comb begin
		pins_next = frame_start ? '1 : pin_q;
		for (int i = 0; i < CHANNELS; i++) begin
			pend_eff[i] = (wr.valid && wr.channel[CH_IDX_W-1:0] == CH_IDX_W'(i))
				? WIDTH_BITS'(wr.width) : pending_q[i];
			act_eff[i] = (frame_start && flag_q[i]) ? pend_eff[i] : active_q[i];
			if (CMP_W'(count_q) >= CMP_W'(act_eff[i])) begin
				pins_next[i] = 1'b0;
			end
		end
		count_inc  = count_q + PERIOD_BITS'(1);
		count_next = (count_inc >= period_q) ? '0 : count_inc;

		res.pin_levels     = MAX_CHANNELS'(is_tick ? pins_next : pin_q);
		res.width_readback = (is_read && ch_ok) ? READ_BITS'(active_q[ch_idx]) : '0;
		res.period_start   = is_tick && frame_start;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pin_q   <= '0;
			flag_q  <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				active_q[i] <= WIDTH_BITS'(RESET_WIDTH);
			end
		end else if (accept) begin
			if (is_tick) begin
				count_q <= count_next;
				pin_q   <= pins_next;
				if (frame_start) begin
					for (int i = 0; i < CHANNELS; i++) begin
						active_q[i] <= act_eff[i];
					end
					flag_q <= '0;
				end
			end else if (is_set && ch_ok) begin
				flag_q[ch_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				pending_q[i] <= WIDTH_BITS'(RESET_WIDTH);
			end
		end else if (wr.valid) begin
			pending_q[wr.channel[CH_IDX_W-1:0]] <= WIDTH_BITS'(wr.width);
		end
	end

	// result buffer: main register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (accept) begin
			if (!main_v_q || pop) begin
				main_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (pop) begin
			main_v_q <= skid_v_q;
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!main_v_q || pop) begin
				main_q <= res;
			end else begin
				skid_q <= res;
			end
		end else if (pop && skid_v_q) begin
			main_q <= skid_q;
		end
	end

	assign rsp.valid          = main_v_q;
	assign rsp.pin_levels     = main_q.pin_levels;
	assign rsp.width_readback = main_q.width_readback;
	assign rsp.period_start   = main_q.period_start;

endmodule
